// ===== sv/bur_pkg.sv =====
package bur_pkg;

    localparam int FIELD_W          = 64;
    localparam int DEF_WORD_BITS    = 64;
    localparam int DEF_MAX_LEVELS   = 64;

    localparam int CFG_IDX_W        = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HIGH = 2'd2;

endpackage

// ===== sv/bounded_uniform_range_reducer.sv =====
// Turns raw words from a random source (range source_low..source_high) into uniform integers
// 0..limit_value by rejection sampling. A limit wider than the source span is drawn over a chain
// of levels kept in three memories with registered reads (limit, bucket, slice per level). After a
// register write the first beat rebuilds the chain, level by level on the shared iterative
// divide/multiply unit (one bit per cycle). Afterwards each upper level walked takes one divide
// and one multiply on the shared unit. One beat is in work at a time; a finished result waits
// in the output register while the next beat is taken.
module bounded_uniform_range_reducer
    import bur_pkg::*;
#(
    parameter int WORD_BITS  = DEF_WORD_BITS,
    parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [FIELD_W-1:0]   i_raw_word,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [FIELD_W-1:0]   o_uniform_value,
    output logic                 o_span_error,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FIELD_W-1:0]   i_cfg_data
);

    localparam int W     = WORD_BITS;
    localparam int AW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CW    = $clog2(MAX_LEVELS + 1);
    localparam int CNT_W = $clog2(W);
    localparam logic [W-1:0]     WMASK    = {W{1'b1}};
    localparam logic [CW-1:0]    LVL_MAX  = CW'(MAX_LEVELS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_BUILD     = 4'd1;
    localparam logic [3:0] S_BLEVEL    = 4'd2;
    localparam logic [3:0] S_BDIV_DONE = 4'd3;
    localparam logic [3:0] S_STEP      = 4'd4;
    localparam logic [3:0] S_LEAF      = 4'd5;
    localparam logic [3:0] S_LEAF_DIV  = 4'd6;
    localparam logic [3:0] S_WALK      = 4'd7;
    localparam logic [3:0] S_WALK_RD   = 4'd8;
    localparam logic [3:0] S_WALK_DIV  = 4'd9;
    localparam logic [3:0] S_WALK_MUL  = 4'd10;
    localparam logic [3:0] S_ITER      = 4'd11;

    logic [W-1:0] mem_limit  [MAX_LEVELS];
    logic [W-1:0] mem_bucket [MAX_LEVELS];
    logic [W-1:0] mem_slice  [MAX_LEVELS];
    logic [W-1:0] rd_limit, rd_bucket, rd_slice;

    logic [W-1:0]     r_limit_value, r_source_low, r_source_high;
    logic [3:0]       r_state, n_state, r_ret, n_ret;
    logic [W-1:0]     r_word, n_word, r_lim, n_lim, r_v, n_v;
    logic [W-1:0]     r_a, n_a, r_r, n_r, r_d, n_d;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_op, n_op;
    logic [CW-1:0]    r_n, n_n, r_level_count, n_level_count, r_cur, n_cur, r_j, n_j;
    logic             r_setup, n_setup;
    logic             r_out_valid;
    logic [W-1:0]     r_out_value;
    logic             r_out_err;

    logic             out_load, out_err, out_free;
    logic [W-1:0]     out_value;
    logic             we_limit, we_bucket, we_slice, rd_en;
    logic [AW-1:0]    wa, ra;
    logic [W-1:0]     bucket_wd, slice_wd;
    logic [W-1:0]     delta, off;
    logic [CW-1:0]    leaf, lvl, k;
    logic [W:0]       div_t;
    logic             cfg_hit;

    assign delta    = r_source_high - r_source_low;
    assign off      = r_word - r_source_low;
    assign leaf     = r_level_count - CW'(1);
    assign lvl      = (r_cur > leaf) ? '0 : r_cur;
    assign k        = r_j - CW'(1);
    assign div_t    = {r_r, r_a[W-1]};
    assign out_free = !r_out_valid || !i_stall;
    assign cfg_hit  = i_cfg_we && (i_cfg_index == CFG_LIMIT_VALUE ||
                      i_cfg_index == CFG_SOURCE_LOW || i_cfg_index == CFG_SOURCE_HIGH);

    always_comb begin
        n_state = r_state;  n_ret = r_ret;  n_word = r_word;  n_lim = r_lim;
        n_v = r_v;  n_a = r_a;  n_r = r_r;  n_d = r_d;  n_cnt = r_cnt;  n_op = r_op;
        n_n = r_n;  n_level_count = r_level_count;  n_cur = r_cur;  n_j = r_j;
        n_setup = r_setup;
        out_load = 1'b0;  out_err = 1'b0;  out_value = '0;
        we_limit = 1'b0;  we_bucket = 1'b0;  we_slice = 1'b0;  rd_en = 1'b0;
        wa = r_n[AW-1:0];  ra = leaf[AW-1:0];
        bucket_wd = '0;  slice_wd = off;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_word  = i_raw_word[W-1:0];
                    n_state = r_setup ? S_STEP : S_BUILD;
                end
            end
            S_BUILD: begin
                n_setup       = 1'b1;
                n_level_count = '0;
                n_cur         = '0;
                n_lim         = r_limit_value;
                n_n           = '0;
                n_state       = (delta == '0) ? S_STEP : S_BLEVEL;
            end
            S_BLEVEL: begin
                if (r_n >= LVL_MAX) begin
                    n_level_count = '0;
                    n_state       = S_STEP;
                end else begin
                    we_limit = 1'b1;
                    n_r = '0;  n_cnt = '0;  n_op = 1'b0;  n_ret = S_BDIV_DONE;
                    if (r_lim <= delta) begin
                        if (r_lim == WMASK) begin
                            we_bucket     = 1'b1;
                            n_level_count = r_n + CW'(1);
                            n_state       = S_STEP;
                        end else begin
                            n_a     = (delta == WMASK) ? WMASK : delta + W'(1);
                            n_d     = r_lim + W'(1);
                            n_state = S_ITER;
                        end
                    end else begin
                        n_a     = r_lim;
                        n_d     = delta + W'(1);
                        n_state = S_ITER;
                    end
                end
            end
            S_BDIV_DONE: begin
                we_bucket = 1'b1;
                if (r_lim <= delta) begin
                    bucket_wd     = r_a;
                    n_level_count = r_n + CW'(1);
                    n_state       = S_STEP;
                end else begin
                    bucket_wd = r_a + W'(1);
                    n_lim     = r_a;
                    n_n       = r_n + CW'(1);
                    n_state   = S_BLEVEL;
                end
            end
            S_STEP: begin
                if (delta == '0 || r_level_count == '0) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        out_err  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (lvl < leaf) begin
                    n_cur = lvl;
                    if (off <= delta) begin
                        we_slice = 1'b1;
                        wa       = lvl[AW-1:0];
                        n_cur    = lvl + CW'(1);
                    end
                    n_state = S_IDLE;
                end else begin
                    n_cur   = lvl;
                    rd_en   = 1'b1;
                    n_j     = leaf;
                    n_state = S_LEAF;
                end
            end
            S_LEAF: begin
                if (rd_limit == WMASK) begin
                    n_v     = r_word;
                    n_state = S_WALK;
                end else if (rd_bucket == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_a = off;  n_d = rd_bucket;  n_r = '0;  n_cnt = '0;
                    n_op = 1'b0;  n_ret = S_LEAF_DIV;  n_state = S_ITER;
                end
            end
            S_LEAF_DIV: begin
                // quotient above the limit means the offset fell past the last whole bucket
                if (r_a > rd_limit) begin
                    n_state = S_IDLE;
                end else begin
                    n_v     = r_a;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_j == '0) begin
                    if (out_free) begin
                        out_load  = 1'b1;
                        out_value = r_v;
                        n_cur     = '0;
                        n_state   = S_IDLE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    ra      = k[AW-1:0];
                    n_state = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (rd_bucket == '0 || r_v > rd_limit) begin
                    n_cur   = k;
                    n_state = S_IDLE;
                end else begin
                    n_a = rd_limit - r_v;  n_d = rd_bucket;  n_r = '0;  n_cnt = '0;
                    n_op = 1'b0;  n_ret = S_WALK_DIV;  n_state = S_ITER;
                end
            end
            S_WALK_DIV: begin
                // slice*bucket + v must not pass this level's limit: retry the level
                if (rd_slice > r_a) begin
                    n_cur   = k;
                    n_state = S_IDLE;
                end else begin
                    n_a = rd_slice;  n_d = rd_bucket;  n_r = '0;  n_cnt = '0;
                    n_op = 1'b1;  n_ret = S_WALK_MUL;  n_state = S_ITER;
                end
            end
            S_WALK_MUL: begin
                n_v     = r_r + r_v;
                n_j     = k;
                n_state = S_WALK;
            end
            S_ITER: begin
                if (r_op) begin
                    n_r = {r_r[W-2:0], 1'b0} + (r_a[W-1] ? r_d : '0);
                    n_a = {r_a[W-2:0], 1'b0};
                end else if (div_t >= {1'b0, r_d}) begin
                    n_r = div_t[W-1:0] - r_d;
                    n_a = {r_a[W-2:0], 1'b1};
                end else begin
                    n_r = div_t[W-1:0];
                    n_a = {r_a[W-2:0], 1'b0};
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = r_ret;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (cfg_hit) begin
            n_setup = 1'b0;
            n_cur   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_limit) begin
            mem_limit[wa] <= r_lim;
        end
        if (we_bucket) begin
            mem_bucket[wa] <= bucket_wd;
        end
        if (we_slice) begin
            mem_slice[wa] <= slice_wd;
        end
        if (rd_en) begin
            rd_limit  <= mem_limit[ra];
            rd_bucket <= mem_bucket[ra];
            rd_slice  <= mem_slice[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_level_count <= '0;
            r_cur         <= '0;
            r_setup       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cnt         <= '0;
            r_limit_value <= W'(255);
            r_source_low  <= '0;
            r_source_high <= WMASK;
        end else begin
            r_state       <= n_state;
            r_level_count <= n_level_count;
            r_cur         <= n_cur;
            r_setup       <= n_setup;
            r_cnt         <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LIMIT_VALUE: r_limit_value <= i_cfg_data[W-1:0];
                    CFG_SOURCE_LOW:  r_source_low  <= i_cfg_data[W-1:0];
                    CFG_SOURCE_HIGH: r_source_high <= i_cfg_data[W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret  <= n_ret;
        r_word <= n_word;
        r_lim  <= n_lim;
        r_v    <= n_v;
        r_a    <= n_a;
        r_r    <= n_r;
        r_d    <= n_d;
        r_op   <= n_op;
        r_n    <= n_n;
        r_j    <= n_j;
        if (out_load) begin
            r_out_value <= out_value;
            r_out_err   <= out_err;
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_uniform_value = FIELD_W'(r_out_value);
    assign o_span_error    = r_out_err;

`ifndef SYNTHESIS
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_span_error |-> o_uniform_value == '0)
        else $error("span error beat carries nonzero value");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_state != S_IDLE)
        else $error("accepted beat left no work");
    a_level_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level_count <= LVL_MAX)
        else $error("level count past maximum");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_uniform_value))
        else $error("stalled result changed");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import bur_pkg::*;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int SETTLE_CYCLES = 20000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [FIELD_W-1:0]   i_raw_word;
    logic                 o_valid;
    logic                 i_stall;
    logic [FIELD_W-1:0]   o_uniform_value;
    logic                 o_span_error;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [FIELD_W-1:0]   i_cfg_data;

    bounded_uniform_range_reducer DUT (.*);

    typedef struct packed {
        logic [63:0] value;
        logic        span_err;
    } draw_t;

    // Predictor state: draw chain per level.
    logic [63:0] p_limit, p_low, p_high;
    logic [63:0] lvl_lim [64];
    logic [63:0] lvl_bkt [64];
    logic [63:0] lvl_slc [64];
    int          cur_lvl, n_lvls;
    bit          chain_ok;

    draw_t expected_draws[$];
    int    mismatches, draws_seen, errs_seen, words_sent;
    bit    idle_on, hold_rx;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("testbench: FAIL");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    function automatic void build_chain();
        logic [63:0] span, lim, b;
        int n;
        span = p_high - p_low;
        lim = p_limit;
        n = 0;
        n_lvls = 0;
        cur_lvl = 0;
        chain_ok = 1;
        if (span == 0) return;
        forever begin
            if (n >= 64) begin
                n_lvls = 0;
                return;
            end
            lvl_lim[n] = lim;
            if (lim <= span) begin
                b = 0;
                if (lim != ALL_ONES)
                    b = (span == ALL_ONES) ? ALL_ONES / (lim + 1) : (span + 1) / (lim + 1);
                lvl_bkt[n] = b;
                n_lvls = n + 1;
                return;
            end
            b = lim / (span + 1) + 1;
            lvl_bkt[n] = b;
            lim = b - 1;
            n++;
        end
    endfunction

    // Returns 1 and fills d when the word completes a draw or yields a span error.
    function automatic bit predict_draw(input logic [63:0] w, output draw_t d);
        logic [63:0] span, off, v, lim, b, s;
        int leaf, lvl;
        d = '0;
        if (!chain_ok) build_chain();
        span = p_high - p_low;
        if (span == 0 || n_lvls == 0) begin
            d.span_err = 1'b1;
            return 1;
        end
        leaf = n_lvls - 1;
        lvl = cur_lvl;
        if (lvl > leaf) begin
            lvl = 0;
            cur_lvl = 0;
        end
        off = w - p_low;
        if (lvl < leaf) begin
            if (off > span) return 0;
            lvl_slc[lvl] = off;
            cur_lvl = lvl + 1;
            return 0;
        end
        lim = lvl_lim[leaf];
        if (lim == ALL_ONES) begin
            v = w;
        end else begin
            b = lvl_bkt[leaf];
            if (b == 0 || off >= b * (lim + 64'd1))
                return 0;
            v = off / b;
        end
        for (int j = leaf; j > 0; j--) begin
            s = lvl_slc[j-1];
            lim = lvl_lim[j-1];
            b = lvl_bkt[j-1];
            if (b == 0 || v > lim || s > (lim - v) / b) begin
                cur_lvl = j - 1;
                return 0;
            end
            v = s * b + v;
        end
        cur_lvl = 0;
        d.value = v;
        return 1;
    endfunction

    task automatic wait_cycles(input int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_LIMIT_VALUE: p_limit = data;
            CFG_SOURCE_LOW:  p_low   = data;
            CFG_SOURCE_HIGH: p_high  = data;
            default: ;
        endcase
        chain_ok = 0;
        cur_lvl = 0;
    endtask

    // Drain expected draws, then let any word still in work settle before a write.
    task automatic quiesce();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (expected_draws.size() != 0 && guard < 2000000) begin
            @(posedge i_clk);
            guard++;
        end
        wait_cycles(SETTLE_CYCLES);
    endtask

    task automatic configure(input logic [63:0] lim, input logic [63:0] lo, input logic [63:0] hi);
        quiesce();
        write_reg(CFG_LIMIT_VALUE, lim);
        write_reg(CFG_SOURCE_LOW, lo);
        write_reg(CFG_SOURCE_HIGH, hi);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_word(input logic [63:0] w);
        draw_t d;
        while (idle_on && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_raw_word <= w;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
        if (predict_draw(w, d)) expected_draws.push_back(d);
    endtask

    // Random word: mostly in the source range, some anywhere.
    function automatic logic [63:0] rand_word();
        logic [63:0] r, span;
        r = {$urandom, $urandom};
        span = p_high - p_low;
        if ($urandom_range(9) < 8 && span != ALL_ONES)
            r = p_low + (r % (span + 1));
        return r;
    endfunction

    // Receiver side: stall generation and result checking.
    always @(posedge i_clk) begin
        if (i_rst_n)
            i_stall <= hold_rx || (idle_on && $urandom_range(99) < 8);
    end

    always @(posedge i_clk) begin
        draw_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_draws.size() == 0) begin
                report("unexpected draw", o_uniform_value, 0);
            end else begin
                want = expected_draws.pop_front();
                if (o_uniform_value !== want.value)
                    report("uniform_value", o_uniform_value, want.value);
                if (o_span_error !== want.span_err)
                    report("span_error", o_span_error, want.span_err);
                if (want.span_err) errs_seen++;
                else draws_seen++;
            end
        end
    end

    task automatic test_directed();
        configure(64'd255, 64'd0, ALL_ONES);
        send_word(64'd0);
        send_word(ALL_ONES);
        send_word(64'hFF00_0000_0000_0000);
        configure(ALL_ONES, 64'd0, ALL_ONES);       // passthrough
        send_word(64'h0123_4567_89AB_CDEF);
        send_word(ALL_ONES);
        configure(64'd0, 64'd5, 64'd5);              // span zero
        send_word(64'd7);
        send_word(64'd5);
        configure(64'd0, 64'd10, 64'd20);            // limit zero
        send_word(64'd10);
        send_word(64'd25);
        configure(64'd999, 64'd10, 64'd19);          // multi-level, offset past span
        for (int i = 0; i < 8; i++) send_word(64'd10 + i * 3);
        send_word(64'd3);
        configure(ALL_ONES, 64'd0, 64'd1);           // 64 levels, binary source
        for (int i = 0; i < 6; i++) send_word(i[0]);
    endtask

    task automatic run_random(input logic [63:0] lim, input logic [63:0] lo,
                              input logic [63:0] hi, input int n_words);
        configure(lim, lo, hi);
        for (int i = 0; i < n_words; i++) send_word(rand_word());
    endtask

    task automatic test_random();
        logic [63:0] lo;
        run_random(64'd6, 64'd0, ALL_ONES, 200);
        lo = {$urandom, $urandom};
        run_random({$urandom, $urandom} >> $urandom_range(63), lo, lo + 64'd1000, 250);
        idle_on = 0;                                  // no-idle stretch
        run_random(64'd1_000_000, 64'd100, 64'd355, 250);
        idle_on = 1;
        run_random(ALL_ONES, 64'd0, ALL_ONES, 150);
        run_random(ALL_ONES - 64'd1, 64'd0, ALL_ONES, 150);
        lo = {$urandom, $urandom};
        run_random(64'd12345, lo, lo + 64'd15, 250);
        run_random({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 250);
        run_random(64'd3, ALL_ONES - 64'd2, 64'd4, 200);   // wrapping source range
    endtask

    task automatic test_backpressure();
        configure(64'd9, 64'd0, ALL_ONES);
        fork
            begin
                hold_rx = 1;
                wait_cycles(3000);
                hold_rx = 0;
            end
            for (int i = 0; i < 40; i++) send_word({$urandom, $urandom});
        join
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_raw_word = '0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_LIMIT_VALUE;
        i_cfg_data = '0;
        idle_on = 1;
        hold_rx = 0;
        mismatches = 0;
        words_sent = 0;
        draws_seen = 0;
        errs_seen = 0;
        p_limit = 64'd255;
        p_low = 64'd0;
        p_high = ALL_ONES;
        chain_ok = 0;
        cur_lvl = 0;
        n_lvls = 0;
        wait_cycles(3);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        quiesce();
        if (expected_draws.size() != 0) begin
            $display("%0d draws never arrived", expected_draws.size());
            mismatches++;
        end
        $display("covered %0d raw words, %0d draws and %0d span errors", words_sent,
                 draws_seen, errs_seen);
        $display("over single-level, multi-level, passthrough and wrapped source ranges");
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/bur_pkg.sv
sv/bounded_uniform_range_reducer.sv
test/testbench.sv
